// ===== rtl/mode_button_led_blink_sequencer_top_assert.svh =====
// Assertion macros used by the blink sequencer top level.
`ifndef MODE_BUTTON_LED_BLINK_SEQUENCER_TOP_ASSERT_SVH
`define MODE_BUTTON_LED_BLINK_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBLS_ASSERT_IMPL(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBLS_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mbls_pkg.sv =====
// Package: constants, lightshow table and shared types of the blink sequencer.
`timescale 1ns / 1ps

package mbls_pkg;

	localparam int NUM_VOICES  = 4;
	localparam int VOICE_IDX_W = 2;
	localparam int MODE_W      = 3;
	localparam int TIME_W      = 32;
	localparam int CFG_W       = 16;
	localparam int DELAY_W     = 10;
	localparam int COUNT_W     = 3;

	// Item kinds
	localparam logic ITEM_PROCESS = 1'b0;
	localparam logic ITEM_GATE    = 1'b1;

	// Register indexes
	localparam logic REG_BLINK_PERIOD = 1'b0;
	localparam logic REG_DEBOUNCE     = 1'b1;

	localparam logic [CFG_W-1:0] RST_BLINK_PERIOD = 16'd100;
	localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 16'd50;

	// Play modes
	localparam logic [MODE_W-1:0] PM_MONO     = 3'd0;
	localparam logic [MODE_W-1:0] PM_CIRCULAR = 3'd1;
	localparam logic [MODE_W-1:0] PM_UNISON   = 3'd2;
	localparam logic [MODE_W-1:0] PM_POLY     = 3'd3;
	localparam logic [MODE_W-1:0] PM_BCH      = 3'd4;
	localparam logic [MODE_W-1:0] PM_CHL      = 3'd5;
	localparam logic [MODE_W-1:0] PM_QUAD     = 3'd6;

	localparam logic [DELAY_W-1:0] DLY_0   = 10'd0;
	localparam logic [DELAY_W-1:0] DLY_200 = 10'd200;
	localparam logic [DELAY_W-1:0] DLY_350 = 10'd350;
	localparam logic [DELAY_W-1:0] DLY_400 = 10'd400;
	localparam logic [DELAY_W-1:0] DLY_600 = 10'd600;

	typedef struct packed {
		logic                 load;
		logic [MODE_W-1:0]    show_mode;
	} btn_evt_t;

	typedef struct packed {
		logic                 load;
		logic                 enable;
		logic [COUNT_W-1:0]   count;
		logic [DELAY_W-1:0]   delay;
	} voice_load_t;

	typedef struct packed {
		logic set;
		logic clr;
	} voice_evt_t;

	// Lightshow table, indexed by the mode being left.
	function automatic logic [MODE_W-1:0] show_next(input logic [MODE_W-1:0] m);
		case (m)
			PM_MONO:     show_next = PM_CIRCULAR;
			PM_CIRCULAR: show_next = PM_UNISON;
			PM_UNISON:   show_next = PM_POLY;
			PM_POLY:     show_next = PM_BCH;
			PM_BCH:      show_next = PM_CHL;
			PM_CHL:      show_next = PM_QUAD;
			default:     show_next = PM_MONO;
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] show_times(input logic [MODE_W-1:0] m);
		case (m)
			PM_MONO, PM_CIRCULAR:                  show_times = 3'd1;
			PM_UNISON:                             show_times = 3'd5;
			PM_POLY, PM_BCH, PM_CHL, PM_QUAD:      show_times = 3'd3;
			default:                               show_times = 3'd0;
		endcase
	endfunction

	function automatic logic [NUM_VOICES-1:0] show_mask(input logic [MODE_W-1:0] m);
		case (m)
			PM_QUAD: show_mask = 4'h1;
			PM_MONO, PM_CIRCULAR, PM_UNISON, PM_POLY, PM_BCH, PM_CHL:
				show_mask = 4'hF;
			default: show_mask = 4'h0;
		endcase
	endfunction

	function automatic logic [DELAY_W-1:0] show_delay(input logic [MODE_W-1:0] m,
			input logic [VOICE_IDX_W-1:0] v);
		show_delay = DLY_0;
		case (m)
			PM_MONO: begin
				case (v)
					2'd0:    show_delay = DLY_0;
					2'd1:    show_delay = DLY_200;
					2'd2:    show_delay = DLY_400;
					default: show_delay = DLY_600;
				endcase
			end
			PM_POLY: show_delay = (v == 2'd0) ? DLY_0 : DLY_600;
			PM_BCH:  show_delay = (v == 2'd3) ? DLY_600 : DLY_0;
			PM_CHL: begin
				case (v)
					2'd0:    show_delay = DLY_200;
					2'd1:    show_delay = DLY_0;
					2'd2:    show_delay = DLY_350;
					default: show_delay = DLY_600;
				endcase
			end
			default: show_delay = DLY_0;
		endcase
	endfunction

endpackage

// ===== rtl/mbls_voice.sv =====
// One voice of the lightshow: start delay, toggle timing and blink countdown.
`timescale 1ns / 1ps

module mbls_voice import mbls_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [TIME_W-1:0] now,
	input  logic [CFG_W-1:0]  period,
	input  voice_load_t       ld,
	output voice_evt_t        evt
);

	localparam int SUM_W = CFG_W + 1;

	logic [COUNT_W-1:0] count_q;
	logic               en_q;
	logic [DELAY_W-1:0] delay_q;
	logic               started_q;
	logic               lit_q;
	logic [TIME_W-1:0]  tt_q;

	logic [COUNT_W-1:0] eff_count;
	logic               eff_en;
	logic [DELAY_W-1:0] eff_delay;
	logic               active;
	logic [SUM_W-1:0]   delay_plus;
	logic [TIME_W-1:0]  thr;
	logic [TIME_W-1:0]  start_time;
	logic               due;
	logic [COUNT_W-1:0] count_n;
	logic               started_n;
	logic [TIME_W-1:0]  tt_n;

	always_comb begin
		eff_count = ld.load ? ld.count  : count_q;
		eff_en    = ld.load ? ld.enable : en_q;
		eff_delay = ld.load ? ld.delay  : delay_q;
		active    = eff_en && (eff_count != '0);

		// Before the first toggle the reference is now + delay, so fold delay and period.
		delay_plus = {{(SUM_W-DELAY_W){1'b0}}, eff_delay} + {1'b0, period};
		start_time = now + {{(TIME_W-DELAY_W){1'b0}}, eff_delay};
		thr = started_q ? (tt_q + {{(TIME_W-CFG_W){1'b0}}, period})
		                : (now + {{(TIME_W-SUM_W){1'b0}}, delay_plus});
		due = active && (now > thr);

		evt.set = due && !lit_q;
		evt.clr = due && lit_q;

		count_n = evt.clr ? (eff_count - 1'b1) : eff_count;
		if (active)
			started_n = !(evt.clr && (count_n == '0));
		else
			started_n = started_q;

		if (due)
			tt_n = now;
		else if (active && !started_q)
			tt_n = start_time;
		else
			tt_n = tt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			en_q      <= 1'b0;
			delay_q   <= '0;
			started_q <= 1'b0;
			lit_q     <= 1'b0;
			tt_q      <= '0;
		end else if (step) begin
			count_q   <= count_n;
			en_q      <= eff_en;
			delay_q   <= eff_delay;
			started_q <= started_n;
			lit_q     <= due ? !lit_q : lit_q;
			tt_q      <= tt_n;
		end
	end

endmodule

// ===== rtl/mbls_button.sv =====
// Mode button: press/release tracking with debounce and play mode advance.
`timescale 1ns / 1ps

module mbls_button import mbls_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [TIME_W-1:0] now,
	input  logic              level,
	input  logic [CFG_W-1:0]  debounce,
	output btn_evt_t          evt,
	output logic [MODE_W-1:0] cur_mode
);

	logic [MODE_W-1:0] mode_q;
	logic              last_q;
	logic [TIME_W-1:0] press_q;
	logic              release_ok;

	always_comb begin
		evt.load      = last_q && !level;
		evt.show_mode = mode_q;
		release_ok    = !last_q && level &&
		                (now > (press_q + {{(TIME_W-CFG_W){1'b0}}, debounce}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= PM_MONO;
			last_q  <= 1'b0;
			press_q <= '0;
		end else if (step) begin
			if (evt.load) begin
				mode_q  <= show_next(mode_q);
				press_q <= now;
				last_q  <= 1'b0;
			end else if (release_ok) begin
				last_q <= 1'b1;
			end
		end
	end

	assign cur_mode = mode_q;

endmodule

// ===== rtl/mode_button_led_blink_sequencer_top.sv =====
// Top level of the mode button LED blink sequencer.
//
// Input channel (in_valid/in_ready): mode selects a gate transaction (load
// gate_bits onto the LEDs) or a process transaction (check the mode button at
// now_ms, then run the four voice blink timers).
// Output channel (out_valid/out_ready): one result per input transaction with
// the LED state, the play mode and a flag set when the transaction advanced the
// play mode.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 writes
// blink_period_ms, 1 writes debounce_ms; write only while the block is idle.
// out_valid rises when a transaction moves from the input register into the
// result register. One transaction per cycle while out_ready stays high; each
// register holds one transaction and the four voice timers update in parallel.
// While the receiver stalls, the result holds and one more transaction may sit
// in the input register; then in_ready drops.
// Reset: play mode mono, LEDs off, all voices idle, registers at 100 and 50 ms.
`timescale 1ns / 1ps

module mode_button_led_blink_sequencer_top import mbls_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  mode,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic                  button_level,
	input  logic [NUM_VOICES-1:0] gate_bits,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [NUM_VOICES-1:0] led_bits,
	output logic [MODE_W-1:0]     play_mode,
	output logic                  mode_changed,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	`include "mode_button_led_blink_sequencer_top_assert.svh"

	logic [CFG_W-1:0]      period_q;
	logic [CFG_W-1:0]      debounce_q;

	logic                  valid_s1;
	logic                  mode_s1;
	logic [TIME_W-1:0]     now_s1;
	logic                  level_s1;
	logic [NUM_VOICES-1:0] gate_s1;

	logic                  out_valid_q;
	logic                  changed_q;
	logic [NUM_VOICES-1:0] led_q;

	logic                  advance;
	logic                  step;
	btn_evt_t              bevt;
	logic [MODE_W-1:0]     cur_mode;
	logic [NUM_VOICES-1:0] mask;
	logic [COUNT_W-1:0]    times;
	logic [NUM_VOICES-1:0] led_set;
	logic [NUM_VOICES-1:0] led_clr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= RST_BLINK_PERIOD;
			debounce_q <= RST_DEBOUNCE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BLINK_PERIOD: period_q   <= cfg_data;
				REG_DEBOUNCE:     debounce_q <= cfg_data;
				default:          period_q   <= period_q;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign step     = advance && (mode_s1 == ITEM_PROCESS);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_valid && in_ready)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1  <= mode;
			now_s1   <= now_ms;
			level_s1 <= button_level;
			gate_s1  <= gate_bits;
		end
	end

	mbls_button u_button (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.now      (now_s1),
		.level    (level_s1),
		.debounce (debounce_q),
		.evt      (bevt),
		.cur_mode (cur_mode)
	);

	assign mask  = show_mask(bevt.show_mode);
	assign times = show_times(bevt.show_mode);

	for (genvar v = 0; v < NUM_VOICES; v++) begin : g_voice
		voice_load_t ld;
		voice_evt_t  vevt;

		assign ld.load   = bevt.load;
		assign ld.enable = mask[v];
		assign ld.count  = mask[v] ? times : '0;
		assign ld.delay  = show_delay(bevt.show_mode, VOICE_IDX_W'(v));

		mbls_voice u_voice (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (step),
			.now    (now_s1),
			.period (period_q),
			.ld     (ld),
			.evt    (vevt)
		);

		assign led_set[v] = vevt.set;
		assign led_clr[v] = vevt.clr;
	end

	// Result register; LED and mode state double as the result payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			changed_q   <= 1'b0;
			led_q       <= '0;
		end else begin
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (advance) begin
				changed_q <= step && bevt.load;
				if (mode_s1 == ITEM_GATE)
					led_q <= gate_s1;
				else
					led_q <= (led_q & ~led_clr) | led_set;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign led_bits     = led_q;
	assign play_mode    = cur_mode;
	assign mode_changed = changed_q;

	`MBLS_ASSERT_NEXT(a_gate_keeps_mode, clk, arst_n, advance && (mode_s1 == ITEM_GATE), play_mode == $past(play_mode), "gate transaction changed the play mode")
	`MBLS_ASSERT_NEXT(a_gate_sets_leds, clk, arst_n, advance && (mode_s1 == ITEM_GATE), led_bits == $past(gate_s1), "gate transaction did not load the LEDs")
	`MBLS_ASSERT_NEXT(a_change_flag, clk, arst_n, advance, mode_changed == (play_mode != $past(play_mode)), "mode_changed disagrees with the play mode")
	`MBLS_ASSERT_IMPL(a_mode_range, clk, arst_n, out_valid, play_mode <= PM_QUAD, "play mode out of range")

endmodule
